FILE: design/stls_pkg.sv
// Shared types, widths, register codes and exponent tables for the sigmoid label-select head.
`default_nettype none

package stls_pkg;

	// Row geometry.
	localparam int MAX_CLASSES = 64;
	localparam int POS_W       = $clog2(MAX_CLASSES);
	localparam int LEN_W       = $clog2(MAX_CLASSES + 1);

	// Field widths of the ports.
	localparam int LOGIT_W  = 16;
	localparam int LABELS_W = 7;
	localparam int INDEX_W  = 6;
	localparam int PROB_W   = 16;
	localparam int THR_W    = 16;
	localparam int CPR_W    = 7;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	// Sigmoid arithmetic: exponent in Q1.30, divider quotient bits.
	localparam int E_W        = 31;
	localparam int FRAC_C_W   = 30;
	localparam int MUL_STAGES = 8;
	localparam int PROD_W     = E_W + FRAC_C_W + 1;
	localparam int DEN_W      = 32;
	localparam int NUM_W      = 48;
	localparam int Q_W        = 17;
	localparam int DIV_STAGES = Q_W;
	localparam logic [E_W-1:0]   E_ONE    = E_W'(1) << 30;
	localparam logic [NUM_W-1:0] NUM_ONE  = NUM_W'(1) << 46;
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << 29;

	// Output queue.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE      = 2'd0,
		CFG_THRESHOLD = 2'd1,
		CFG_CLASSES   = 2'd2
	} cfg_index_t;

	// Per-request side information carried alongside the sigmoid pipeline.
	typedef struct packed {
		logic [LABELS_W-1:0] labels;
		logic                mode;
		logic [THR_W-1:0]    threshold;
		logic [LEN_W-1:0]    row_len;
	} tag_t;

	// One output request.
	typedef struct packed {
		logic [INDEX_W-1:0] label_index;
		logic [PROB_W-1:0]  probability;
		logic               has_label;
		logic               unknown_label;
		logic               row_end;
	} result_t;

	// exp(-n) in Q1.30 for integer n below 16.
	function automatic logic [E_W-1:0] exp_int(input logic [3:0] n);
		logic [E_W-1:0] v;
		case (n)
			4'd0:    v = 31'd1073741824;
			4'd1:    v = 31'd395007542;
			4'd2:    v = 31'd145315154;
			4'd3:    v = 31'd53458458;
			4'd4:    v = 31'd19666268;
			4'd5:    v = 31'd7234816;
			4'd6:    v = 31'd2661540;
			4'd7:    v = 31'd979126;
			4'd8:    v = 31'd360200;
			4'd9:    v = 31'd132510;
			4'd10:   v = 31'd48748;
			4'd11:   v = 31'd17933;
			4'd12:   v = 31'd6597;
			4'd13:   v = 31'd2427;
			4'd14:   v = 31'd893;
			4'd15:   v = 31'd328;
			default: v = '0;
		endcase
		return v;
	endfunction

	// exp(-2^k/256) in Q0.30 for fraction bit k.
	function automatic logic [FRAC_C_W-1:0] exp_frac(input logic [2:0] k);
		logic [FRAC_C_W-1:0] v;
		case (k)
			3'd0:    v = 30'd1069555701;
			3'd1:    v = 30'd1065385899;
			3'd2:    v = 30'd1057095000;
			3'd3:    v = 30'd1040706261;
			3'd4:    v = 30'd1008687095;
			3'd5:    v = 30'd947573834;
			3'd6:    v = 30'd836230973;
			3'd7:    v = 30'd651257337;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: design/sigmoid_threshold_label_select_core.sv
// Top level of the sigmoid threshold label-select head: row tracking, selection and output queue.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    logit, row_labels
//  out      output     out_valid / out_stall  label_index, probability, has_label,
//                                             unknown_label, row_end
//  cfg      input      cfg_we                 cfg_index, cfg_data
//
// One logit request is taken per cycle while in_stall is low; it passes through the input
// register, the 8 exponent multiply stages, the divider setup and the 17-stage bit-per-stage divider.
// A logit that both selects a label and closes a row yields two output requests; the
// output port drains one per cycle while out_stall is low, so the 4-entry output queue throttles the input.
// The whole pipeline holds while fewer than two queue slots are free.
// arst_n clears all valid bits, the row state and the registers to their defaults.
`default_nettype none

module sigmoid_threshold_label_select_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [stls_pkg::LOGIT_W-1:0] logit,
	input  logic [stls_pkg::LABELS_W-1:0]     row_labels,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [stls_pkg::INDEX_W-1:0]      label_index,
	output logic [stls_pkg::PROB_W-1:0]       probability,
	output logic                              has_label,
	output logic                              unknown_label,
	output logic                              row_end,
	input  logic                              cfg_we,
	input  logic [stls_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [stls_pkg::CFG_W-1:0]        cfg_data
);
	import stls_pkg::*;

	logic                 mode_q;
	logic [THR_W-1:0]     threshold_q;
	logic [CPR_W-1:0]     classes_q;

	logic [LEN_W-1:0]     row_len;
	tag_t                 in_tag;
	logic                 adv;

	logic                 sig_valid;
	logic [PROB_W-1:0]    sig_prob;
	tag_t                 sig_tag;

	logic [POS_W-1:0]     pos_q;
	logic [LEN_W-1:0]     act_q;
	logic [PROB_W-1:0]    best_q;
	logic [POS_W-1:0]     bidx_q;

	logic                 first;
	logic [LEN_W-1:0]     act_eff;
	logic [PROB_W-1:0]    best_eff;
	logic [POS_W-1:0]     bidx_eff;
	logic                 part;
	logic                 last;
	logic                 better;
	logic [PROB_W-1:0]    best_nxt;
	logic [POS_W-1:0]     bidx_nxt;
	logic                 lab_valid;
	result_t              lab_res;
	result_t              end_res;
	logic                 take;

	result_t              fifo_q [0:FIFO_DEPTH-1];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   cnt_q;
	logic                 push_a;
	logic                 push_b;
	logic [1:0]           push_n;
	logic                 pop;
	result_t              head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			threshold_q <= THR_W'(32768);
			classes_q   <= CPR_W'(MAX_CLASSES);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE:      mode_q      <= cfg_data[0];
				CFG_THRESHOLD: threshold_q <= cfg_data[THR_W-1:0];
				CFG_CLASSES:   classes_q   <= cfg_data[CPR_W-1:0];
				default:       ;
			endcase
		end
	end

	// Row length clamped to one through the largest row; settings travel with the request.
	always_comb begin
		if (classes_q == '0) begin
			row_len = LEN_W'(1);
		end else if (LEN_W'(classes_q) > LEN_W'(MAX_CLASSES)) begin
			row_len = LEN_W'(MAX_CLASSES);
		end else begin
			row_len = LEN_W'(classes_q);
		end
		in_tag.labels    = row_labels;
		in_tag.mode      = mode_q;
		in_tag.threshold = threshold_q;
		in_tag.row_len   = row_len;
	end

	// The pipeline moves only while the queue can absorb two more results.
	assign adv      = cnt_q <= FIFO_CW'(FIFO_DEPTH - 2);
	assign in_stall = !adv;

	stls_sigmoid u_sigmoid (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_valid),
		.logit     (logit),
		.in_tag    (in_tag),
		.out_valid (sig_valid),
		.prob      (sig_prob),
		.out_tag   (sig_tag)
	);

	// Selection: row position, active label count and running maximum.
	always_comb begin
		first    = pos_q == '0;
		act_eff  = (LEN_W'(sig_tag.labels) > sig_tag.row_len) ? sig_tag.row_len
			: LEN_W'(sig_tag.labels);
		if (!first) begin
			act_eff = act_q;
		end
		best_eff = first ? '0 : best_q;
		bidx_eff = first ? '0 : bidx_q;
		part     = LEN_W'(pos_q) < act_eff;
		last     = (LEN_W'(pos_q) + LEN_W'(1)) >= sig_tag.row_len;
		better   = part && (sig_prob > best_eff);
		best_nxt = better ? sig_prob : best_eff;
		bidx_nxt = better ? pos_q : bidx_eff;

		if (!sig_tag.mode) begin
			lab_valid             = part && (sig_prob >= sig_tag.threshold);
			lab_res.label_index   = INDEX_W'(pos_q);
			lab_res.probability   = sig_prob;
			lab_res.unknown_label = 1'b0;
		end else begin
			lab_valid             = last && (best_nxt >= sig_tag.threshold);
			lab_res.label_index   = INDEX_W'(bidx_nxt);
			lab_res.probability   = best_nxt;
			lab_res.unknown_label = act_eff == '0;
		end
		lab_res.has_label = 1'b1;
		lab_res.row_end   = 1'b0;

		end_res.label_index   = '0;
		end_res.probability   = '0;
		end_res.has_label     = 1'b0;
		end_res.unknown_label = 1'b0;
		end_res.row_end       = 1'b1;
	end

	assign take = sig_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			act_q  <= '0;
			best_q <= '0;
			bidx_q <= '0;
		end else if (take) begin
			pos_q  <= last ? '0 : pos_q + POS_W'(1);
			act_q  <= act_eff;
			best_q <= best_nxt;
			bidx_q <= bidx_nxt;
		end
	end

	// Output queue: up to two writes and one read per cycle, label result before row end.
	assign push_a = take && (lab_valid || last);
	assign push_b = take && lab_valid && last;
	assign push_n = 2'(push_a) + 2'(push_b);
	assign pop    = (cnt_q != '0) && !out_stall;

	always_ff @(posedge clk) begin
		if (push_a) begin
			fifo_q[wr_ptr_q] <= lab_valid ? lab_res : end_res;
		end
		if (push_b) begin
			fifo_q[wr_ptr_q + FIFO_AW'(1)] <= end_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_n);
			rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
			cnt_q    <= cnt_q + FIFO_CW'(push_n) - FIFO_CW'(pop);
		end
	end

	// Output port reads the queue head.
	assign head          = fifo_q[rd_ptr_q];
	assign out_valid     = cnt_q != '0;
	assign label_index   = head.label_index;
	assign probability   = head.probability;
	assign has_label     = head.has_label;
	assign unknown_label = head.unknown_label;
	assign row_end       = head.row_end;

	// The queue never holds more than its depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("output queue overflow");

	// A row-end request carries no label.
	a_end_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row_end |-> !has_label && !unknown_label && probability == '0
			&& label_index == '0)
		else $error("row-end request carries label data");

	// An unknown-label flag only rides on a label request.
	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unknown_label |-> has_label && !row_end)
		else $error("unknown flag without a label");

	// A held head with no new writes keeps the queue level.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall && push_n == 2'd0 |=> $stable(cnt_q))
		else $error("queue level changed while stalled");

	// Two writes in one cycle happen only on a row's last request.
	a_two_push: assert property (@(posedge clk) disable iff (!arst_n)
		push_b |-> push_a && last)
		else $error("second write outside row end");

endmodule

`default_nettype wire

FILE: design/stls_sigmoid.sv
// Pipelined fixed-point sigmoid: exponent by table and eight multiply stages, then a bit-per-stage divider.
`default_nettype none

module stls_sigmoid (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         in_valid,
	input  logic [stls_pkg::LOGIT_W-1:0] logit,
	input  stls_pkg::tag_t               in_tag,
	output logic                         out_valid,
	output logic [stls_pkg::PROB_W-1:0]  prob,
	output stls_pkg::tag_t               out_tag
);
	import stls_pkg::*;

	typedef struct packed {
		logic [E_W-1:0]        e;
		logic [MUL_STAGES-1:0] f;
		logic                  neg;
		tag_t                  tag;
	} mul_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [Q_W-1:0]   lowq;
		logic [DEN_W-1:0] den;
		tag_t             tag;
	} div_t;

	logic                 mul_vld_s [0:MUL_STAGES];
	mul_t                 mul_s     [0:MUL_STAGES];
	logic                 div_vld_s [0:DIV_STAGES];
	div_t                 div_s     [0:DIV_STAGES];

	logic [LOGIT_W-1:0]   mag;
	logic                 neg;
	logic [7:0]           int_part;
	mul_t                 prep;
	logic [DEN_W-1:0]     den;
	logic [NUM_W-1:0]     num;
	div_t                 setup;
	logic [Q_W-1:0]       quot;

	// Input stage: magnitude, integer exponent from the table, fraction bits.
	always_comb begin
		neg      = logit[LOGIT_W-1];
		mag      = neg ? (~logit + LOGIT_W'(1)) : logit;
		int_part = mag[15:8];
		prep.e   = (int_part < 8'd16) ? exp_int(int_part[3:0]) : '0;
		prep.f   = mag[7:0];
		prep.neg = neg;
		prep.tag = in_tag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_vld_s[0] <= 1'b0;
		end else if (adv) begin
			mul_vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mul_s[0] <= prep;
		end
	end

	// One multiply per fraction bit, rounded half up back to Q1.30.
	for (genvar k = 0; k < MUL_STAGES; k++) begin : g_mul
		logic [PROD_W-1:0] prod;
		mul_t              nxt;

		always_comb begin
			prod = PROD_W'(mul_s[k].e) * PROD_W'(exp_frac(3'(k))) + ROUND_HALF;
			nxt  = mul_s[k];
			if (mul_s[k].f[k]) begin
				nxt.e = prod[E_W+29:30];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mul_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				mul_vld_s[k+1] <= mul_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				mul_s[k+1] <= nxt;
			end
		end
	end

	// Divider setup: denominator 1+E, rounded numerator, top quotient bits known zero.
	always_comb begin
		den        = DEN_W'(E_ONE) + DEN_W'(mul_s[MUL_STAGES].e);
		num        = (mul_s[MUL_STAGES].neg ? (NUM_W'(mul_s[MUL_STAGES].e) << 16) : NUM_ONE)
			+ NUM_W'(den >> 1);
		setup.rem  = DEN_W'(num[NUM_W-1:Q_W]);
		setup.lowq = num[Q_W-1:0];
		setup.den  = den;
		setup.tag  = mul_s[MUL_STAGES].tag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s[0] <= 1'b0;
		end else if (adv) begin
			div_vld_s[0] <= mul_vld_s[MUL_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0] <= setup;
		end
	end

	// Restoring division, one quotient bit per stage shifted into the low word.
	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		logic [DEN_W:0] trial;
		logic           ge;
		div_t           nxt;

		always_comb begin
			trial    = {div_s[j].rem, div_s[j].lowq[Q_W-1]};
			ge       = trial >= {1'b0, div_s[j].den};
			nxt      = div_s[j];
			nxt.rem  = ge ? DEN_W'(trial - {1'b0, div_s[j].den}) : trial[DEN_W-1:0];
			nxt.lowq = {div_s[j].lowq[Q_W-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[j+1] <= 1'b0;
			end else if (adv) begin
				div_vld_s[j+1] <= div_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[j+1] <= nxt;
			end
		end
	end

	// Saturate a quotient of exactly 1.0 to the largest Q0.16 code.
	assign quot      = div_s[DIV_STAGES].lowq;
	assign prob      = quot[Q_W-1] ? '1 : quot[PROB_W-1:0];
	assign out_valid = div_vld_s[DIV_STAGES];
	assign out_tag   = div_s[DIV_STAGES].tag;

endmodule

`default_nettype wire
